[sv/image_ring_slot_picker_macros.svh]
// Assertion macros for the image ring slot picker modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef IMAGE_RING_SLOT_PICKER_MACROS_SVH
`define IMAGE_RING_SLOT_PICKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IRSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IRSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/irsp_pkg.sv]
// ----------------------------------------------------------------------------
// Image ring slot picker package
// Item types, command codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package irsp_pkg;

  localparam int MaxSlotsDefault = 4;
  localparam int CountW          = 3;
  localparam logic [CountW-1:0] SlotCountReset = 3'd1;

  typedef enum logic [2:0] {
    CMD_OBSERVE = 3'd0,
    CMD_PICK    = 3'd1,
    CMD_PUBLISH = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_RECLAIM = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        held_present;
    logic [2:0]  slot_index;
    logic [63:0] frame_number;
    logic [63:0] release_stamp;
  } in_item_t;

  typedef struct packed {
    logic        pick_found;
    logic [1:0]  picked_slot;
    logic [63:0] release_needed;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_pick;
    logic scan_done;
  } dp_status_t;

endpackage

[sv/irsp_datapath.sv]
// ----------------------------------------------------------------------------
// Image ring slot picker datapath
// Slot tables, marks, slot count, one-slot-per-cycle pick scan and result
// registers.
// ----------------------------------------------------------------------------
module irsp_datapath import irsp_pkg::*; #(
  parameter int MAX_SLOTS = MaxSlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_write_i,
  input  logic [CountW-1:0] cfg_data_i,
  input  in_item_t          in_data_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  output out_item_t         out_data_o
);

  localparam int IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  in_item_t          item_q;
  logic [63:0]       last_frame_q [MAX_SLOTS];
  logic [63:0]       thr_q        [MAX_SLOTS];
  logic              pub_valid_q, held_valid_q;
  logic [2:0]        pub_slot_q, held_mark_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] scan_q;
  logic              found_q;
  logic [1:0]        picked_q;
  logic [63:0]       best_q, needed_q;
  out_item_t         out_q;

  logic              item_is_pick, in_range, cfg_ok;
  logic [IdxW-1:0]   rd_addr;
  logic [63:0]       rd_frame, rd_thr;
  logic              excluded, thr_ok, take;

  assign item_is_pick = (item_q.cmd == CMD_PICK);
  assign in_range     = (item_q.slot_index < count_q);
  assign cfg_ok       = (cfg_data_i != '0) && (32'(cfg_data_i) <= 32'(MAX_SLOTS));

  // The scan walks the slots during a pick; every other command uses its own index.
  assign rd_addr  = item_is_pick ? IdxW'(scan_q) : IdxW'(item_q.slot_index);
  assign rd_frame = last_frame_q[rd_addr];
  assign rd_thr   = thr_q[rd_addr];

  assign excluded = (pub_valid_q && (pub_slot_q == scan_q)) ||
                    (held_valid_q && (held_mark_q == scan_q));
  assign thr_ok   = (rd_thr == '0) || (item_q.release_stamp >= rd_thr);
  assign take     = !excluded && thr_ok && (!found_q || (rd_frame < best_q));

  assign status_o.is_pick   = item_is_pick;
  assign status_o.scan_done = (scan_q == count_q);
  assign out_data_o         = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        last_frame_q[i] <= '0;
        thr_q[i]        <= '0;
      end
      pub_valid_q  <= 1'b0;
      pub_slot_q   <= '0;
      held_valid_q <= 1'b0;
      held_mark_q  <= '0;
      count_q      <= SlotCountReset;
    end else if (cfg_write_i && cfg_ok) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        last_frame_q[i] <= '0;
        thr_q[i]        <= '0;
      end
      pub_valid_q  <= 1'b0;
      pub_slot_q   <= '0;
      held_valid_q <= 1'b0;
      held_mark_q  <= '0;
      count_q      <= cfg_data_i;
    end else if (cmd_i.exec) begin
      unique case (item_q.cmd)
        CMD_OBSERVE: begin
          if (!item_q.held_present) begin
            held_valid_q <= 1'b0;
          end else begin
            held_valid_q <= 1'b1;
            held_mark_q  <= item_q.slot_index;
            // The held frame arms the slot only if it is still the slot's latest.
            if (in_range && (rd_frame == item_q.frame_number)) begin
              thr_q[rd_addr] <= item_q.frame_number;
            end
          end
        end
        CMD_PUBLISH: begin
          if (in_range) begin
            last_frame_q[rd_addr] <= item_q.frame_number;
          end
          pub_valid_q <= 1'b1;
          pub_slot_q  <= item_q.slot_index;
        end
        CMD_RECLAIM: begin
          for (int i = 0; i < MAX_SLOTS; i++) begin
            thr_q[i] <= '0;
          end
          held_valid_q <= 1'b0;
          pub_valid_q  <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (cmd_i.capture) begin
      scan_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_q <= scan_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      found_q  <= 1'b0;
      picked_q <= '0;
      best_q   <= '0;
      needed_q <= '0;
    end else begin
      if (cmd_i.exec && (item_q.cmd == CMD_QUERY) && in_range) begin
        needed_q <= rd_thr;
      end
      if (cmd_i.scan_step && take) begin
        found_q  <= 1'b1;
        picked_q <= 2'(scan_q);
        best_q   <= rd_frame;
      end
    end
    if (cmd_i.load_out) begin
      out_q.pick_found     <= found_q;
      out_q.picked_slot    <= picked_q;
      out_q.release_needed <= needed_q;
    end
  end

endmodule

[sv/irsp_controller.sv]
// ----------------------------------------------------------------------------
// Image ring slot picker controller
// Sequences decode, command execution or slot scan, and the output register.
// ----------------------------------------------------------------------------
`include "image_ring_slot_picker_macros.svh"

module irsp_controller import irsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       cfg_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_pick) begin
          state_d = ST_SCAN;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  `IRSP_ASSERT_IMP(a_load_needs_room, cmd_o.load_out, !out_valid_q || !out_stall_i, "result overwritten while waiting")
  `IRSP_ASSERT_NXT(a_accept_goes_busy, in_valid_i && !in_stall_o, state_q == ST_EXEC, "item accepted without starting work")
  `IRSP_ASSERT_NXT(a_emit_shows_result, state_q == ST_EMIT && !out_valid_q, out_valid_q && state_q == ST_IDLE, "finished item not presented")

endmodule

[sv/image_ring_slot_picker.sv]
// A result is presented once its item has passed the exec and emit states, and a pick
// also passes the scan state, whose single scan compares one slot per cycle.
// The block takes no new item until the current result is loaded into the output
// register; a result left waiting holds the next item in the emit state.
// Reset clears all slot tables and marks at once and sets the slot count to one.
// ----------------------------------------------------------------------------
// Image ring slot picker
// Chooses the next image slot to render into and tracks release thresholds.
// ----------------------------------------------------------------------------
module image_ring_slot_picker import irsp_pkg::*; #(
  parameter int MAX_SLOTS = MaxSlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  irsp_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cfg_ready_o(cfg_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  irsp_datapath #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_write_i(cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Image ring slot picker testbench
// Sends observe, pick, publish, query, reclaim and unknown-code items under random
// stalls on both sides. A predictor inside the bench tracks slot frames, thresholds and
// marks, and every result is checked against it in order.
// ----------------------------------------------------------------------------
module tb;
  import irsp_pkg::*;

  localparam int Slots       = MaxSlotsDefault;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 16;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_item_t          in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_item_t         out_data_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_data_i;

  image_ring_slot_picker #(
    .MAX_SLOTS(Slots)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Predicted ring state.
  logic [63:0] frame_of_slot     [Slots];
  logic [63:0] threshold_of_slot [Slots];
  logic        published_ok;
  logic [2:0]  published_at;
  logic        held_ok;
  logic [2:0]  held_at;
  int unsigned slots_in_use;

  out_item_t   ring_results_due [$];
  logic [63:0] frame_clock = 64'd1;
  bit          idling_on = 1'b1;
  int          sink_hold_cycles = 0;
  int          error_count = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          unknown_sent = 0;
  int          picks_sent = 0;
  int          picks_found = 0;
  int          cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t ring_cmd(logic [2:0] c, logic present, logic [2:0] idx,
                                        logic [63:0] frame, logic [63:0] rel);
    in_item_t it;
    it.cmd           = c;
    it.held_present  = present;
    it.slot_index    = idx;
    it.frame_number  = frame;
    it.release_stamp = rel;
    return it;
  endfunction

  function automatic void clear_ring_model();
    for (int i = 0; i < Slots; i++) begin
      frame_of_slot[i]     = '0;
      threshold_of_slot[i] = '0;
    end
    published_ok = 1'b0;
    published_at = '0;
    held_ok      = 1'b0;
    held_at      = '0;
  endfunction

  function automatic void apply_count_write(logic [CountW-1:0] v);
    // Counts of zero or above the ring size leave everything as it was.
    if (v != 0 && v <= Slots) begin
      slots_in_use = v;
      clear_ring_model();
    end
  endfunction

  function automatic out_item_t predict_ring_result(in_item_t it);
    out_item_t   r;
    logic [63:0] oldest;
    r      = '0;
    oldest = '0;
    case (it.cmd)
      CMD_OBSERVE: begin
        if (!it.held_present) begin
          held_ok = 1'b0;
        end else begin
          held_ok = 1'b1;
          held_at = it.slot_index;
          if (it.slot_index < slots_in_use &&
              frame_of_slot[it.slot_index] == it.frame_number)
            threshold_of_slot[it.slot_index] = it.frame_number;
        end
      end
      CMD_PICK: begin
        for (int i = 0; i < slots_in_use; i++) begin
          if (published_ok && published_at == i) continue;
          if (held_ok && held_at == i) continue;
          if (threshold_of_slot[i] != 0 && it.release_stamp < threshold_of_slot[i]) continue;
          if (!r.pick_found || frame_of_slot[i] < oldest) begin
            r.pick_found  = 1'b1;
            r.picked_slot = 2'(i);
            oldest        = frame_of_slot[i];
          end
        end
      end
      CMD_PUBLISH: begin
        if (it.slot_index < slots_in_use) frame_of_slot[it.slot_index] = it.frame_number;
        published_ok = 1'b1;
        published_at = it.slot_index;
      end
      CMD_QUERY: begin
        if (it.slot_index < slots_in_use)
          r.release_needed = threshold_of_slot[it.slot_index];
      end
      CMD_RECLAIM: begin
        for (int i = 0; i < Slots; i++) threshold_of_slot[i] = '0;
        held_ok      = 1'b0;
        published_ok = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Offers one item, possibly after a random gap, and returns at the edge
  // where it is taken. Valid stays high so that items can follow back to back.
  task automatic send_ring_item(in_item_t it);
    out_item_t due;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    due = predict_ring_result(it);
    ring_results_due.push_back(due);
    if (it.cmd > CMD_RECLAIM) begin
      unknown_sent++;
    end else begin
      items_sent++;
    end
    if (it.cmd == CMD_PICK) begin
      picks_sent++;
      if (due.pick_found) picks_found++;
    end
  endtask

  task automatic wait_ring_drained();
    in_valid_i <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_slot_count(logic [CountW-1:0] v);
    wait_ring_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_count_write(v);
  endtask

  task automatic test_directed_commands();
    logic [63:0] ones;
    ones = '1;
    write_slot_count(3'd4);
    send_ring_item(ring_cmd(CMD_QUERY, 1'b0, 3'd0, '0, '0));
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, '0));
    send_ring_item(ring_cmd(CMD_PUBLISH, 1'b0, 3'd0, ones, '0));
    send_ring_item(ring_cmd(CMD_OBSERVE, 1'b1, 3'd0, ones, '0));
    send_ring_item(ring_cmd(CMD_QUERY, 1'b0, 3'd0, '0, ones));
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, '0));
    send_ring_item(ring_cmd(CMD_PUBLISH, 1'b0, 3'd2, 64'd3, '0));
    send_ring_item(ring_cmd(CMD_OBSERVE, 1'b1, 3'd2, 64'd3, '0));
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, 64'd2));
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, ones));
    // A held frame that differs from the slot's last frame arms nothing.
    send_ring_item(ring_cmd(CMD_OBSERVE, 1'b1, 3'd3, 64'd9, '0));
    send_ring_item(ring_cmd(CMD_QUERY, 1'b0, 3'd3, '0, '0));
    send_ring_item(ring_cmd(CMD_OBSERVE, 1'b0, 3'd3, ones, ones));
    // Marks at or above the slot count exclude nothing and arm nothing.
    send_ring_item(ring_cmd(CMD_PUBLISH, 1'b0, 3'd7, ones, '0));
    send_ring_item(ring_cmd(CMD_OBSERVE, 1'b1, 3'd5, '0, '0));
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, '0));
    send_ring_item(ring_cmd(CMD_QUERY, 1'b0, 3'd4, ones, ones));
    send_ring_item(ring_cmd(CMD_QUERY, 1'b0, 3'd7, ones, ones));
    send_ring_item(ring_cmd(CMD_RECLAIM, 1'b1, 3'd0, ones, ones));
    send_ring_item(ring_cmd(CMD_QUERY, 1'b0, 3'd0, '0, '0));
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, '0));
    for (int c = int'(CMD_RECLAIM) + 1; c < 8; c++)
      send_ring_item(ring_cmd(3'(c), 1'b1, 3'd1, ones, ones));
  endtask

  task automatic test_slot_count_settings();
    write_slot_count(3'd1);
    send_ring_item(ring_cmd(CMD_PUBLISH, 1'b0, 3'd0, 64'd5, '0));
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, '0));
    send_ring_item(ring_cmd(CMD_OBSERVE, 1'b1, 3'd0, 64'd5, '0));
    send_ring_item(ring_cmd(CMD_PUBLISH, 1'b0, 3'd1, 64'd2, '0));
    send_ring_item(ring_cmd(CMD_OBSERVE, 1'b0, 3'd0, '0, '0));
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, 64'd4));
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, 64'd5));
    // Out-of-range counts must leave the threshold armed above in place.
    write_slot_count(3'd0);
    write_slot_count(3'd5);
    write_slot_count(3'd6);
    write_slot_count(3'd7);
    send_ring_item(ring_cmd(CMD_QUERY, 1'b0, 3'd0, '0, '0));
    write_slot_count(3'd2);
    send_ring_item(ring_cmd(CMD_QUERY, 1'b0, 3'd0, '0, '0));
    send_ring_item(ring_cmd(CMD_PUBLISH, 1'b0, 3'd1, 64'd8, '0));
    send_ring_item(ring_cmd(CMD_OBSERVE, 1'b1, 3'd1, 64'd8, '0));
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, 64'd7));
    write_slot_count(3'd3);
    send_ring_item(ring_cmd(CMD_PICK, 1'b0, 3'd0, '0, '0));
  endtask

  // Mostly publish, observe, pick and query runs on a rising frame number,
  // with reclaims, released holds and fully random items mixed in.
  task automatic test_random_traffic(int n);
    int          start;
    logic [2:0]  slot;
    logic [63:0] frame;
    logic [63:0] rel;
    logic [63:0] thr;
    start = items_sent;
    while (items_sent - start < n) begin
      slot = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(0, slots_in_use - 1));
      frame_clock += 64'($urandom_range(1, 3));
      if ($urandom_range(0, 29) == 0) frame_clock = rand64();
      case ($urandom_range(0, 9))
        0: begin
          send_ring_item(ring_cmd(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                  3'($urandom_range(0, 7)), rand64(), rand64()));
        end
        1: begin
          if ($urandom_range(0, 1) == 0) begin
            send_ring_item(ring_cmd(CMD_RECLAIM, 1'b0, slot, rand64(), rand64()));
          end else begin
            send_ring_item(ring_cmd(CMD_OBSERVE, 1'b0, slot, rand64(), rand64()));
          end
        end
        default: begin
          send_ring_item(ring_cmd(CMD_PUBLISH, 1'b0, slot, frame_clock, rand64()));
          if ($urandom_range(0, 3) != 0) begin
            frame = ($urandom_range(0, 5) == 0) ? frame_clock ^ 64'd1 : frame_clock;
            send_ring_item(ring_cmd(CMD_OBSERVE, 1'b1, slot, frame, rand64()));
          end
          thr = threshold_of_slot[$urandom_range(0, Slots - 1)];
          case ($urandom_range(0, 4))
            0:       rel = '0;
            1:       rel = thr - 64'd1;
            2:       rel = thr;
            3:       rel = frame_clock;
            default: rel = rand64();
          endcase
          send_ring_item(ring_cmd(CMD_PICK, 1'b0, slot, rand64(), rel));
          if ($urandom_range(0, 2) == 0)
            send_ring_item(ring_cmd(CMD_QUERY, 1'b0, 3'($urandom_range(0, 7)),
                                    rand64(), rand64()));
        end
      endcase
    end
  endtask

  // The receiver holds off long enough for the block to back up onto its
  // input, then the sender waits for every outstanding result.
  task automatic test_backpressure();
    bit saved;
    saved            = idling_on;
    idling_on        = 1'b0;
    sink_hold_cycles = 150;
    test_random_traffic(24);
    wait_ring_drained();
    idling_on = saved;
  endtask

  initial begin
    forever begin
      if (sink_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (ring_results_due.size() == 0) begin
        $error("result arrived with nothing outstanding: %p", out_data_o);
        error_count++;
      end else begin
        due = ring_results_due.pop_front();
        if (out_data_o.pick_found !== due.pick_found) begin
          $error("pick_found: expected %0d, got %0d", due.pick_found, out_data_o.pick_found);
          error_count++;
        end
        if (out_data_o.picked_slot !== due.picked_slot) begin
          $error("picked_slot: expected %0d, got %0d", due.picked_slot,
                 out_data_o.picked_slot);
          error_count++;
        end
        if (out_data_o.release_needed !== due.release_needed) begin
          $error("release_needed: expected %h, got %h", due.release_needed,
                 out_data_o.release_needed);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               ring_results_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= SlotCountReset;
    slots_in_use = SlotCountReset;
    clear_ring_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_commands();
    test_slot_count_settings();
    for (int k = 1; k <= Slots; k++) begin
      write_slot_count(3'(k));
      test_random_traffic(60);
    end
    test_backpressure();
    write_slot_count(3'($urandom_range(1, Slots)));
    test_random_traffic(40);
    idling_on = 1'b0;
    test_random_traffic(40);

    wait_ring_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (ring_results_due.size() != 0) begin
      $error("%0d results never arrived", ring_results_due.size());
      error_count++;
    end
    $display("Checked %0d results: %0d commands, %0d unknown codes, %0d picks, %0d found.",
             results_seen, items_sent, unknown_sent, picks_sent, picks_found);
    $display("Slot counts 1 to 4 and ignored counts were written, with stalls on both sides.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
